@@ src/tcs_pkg.sv @@
// Package: shared constants, codes and item types of the TCP transmit segmenter.
package tcs_pkg;

    localparam int WORD_BYTES = 8;
    localparam int DATA_W     = WORD_BYTES * 8;
    localparam int KEEP_W     = WORD_BYTES;
    localparam int DEST_W     = 8;
    localparam int SESS_W     = 16;
    localparam int LEN_W      = 16;
    localparam int BYTES_W    = 32;
    localparam int CNT_W      = 14;

    // ceil(len / WORD_BYTES) through a reciprocal; exact for len below 2^16
    localparam int RECIP_SH = 24;
    localparam int QIN_W    = LEN_W + 1;
    localparam int PROD_W   = QIN_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP =
        RECIP_SH'(((1 << RECIP_SH) + WORD_BYTES - 1) / WORD_BYTES);

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_CLOSED = 2'd1;

    localparam logic OUT_META = 1'b0;
    localparam logic OUT_WORD = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STATUS = 3'b010,
        PH_WORDS  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SESS_W-1:0]  session_id;
        logic [BYTES_W-1:0] total_bytes;
        logic [BYTES_W-1:0] max_words;
        logic [LEN_W-1:0]   status_length;
        logic [1:0]         status_error;
        logic [DATA_W-1:0]  in_data;
        logic [KEEP_W-1:0]  in_keep;
        logic [DEST_W-1:0]  in_dest;
    } t_in_item;

    typedef struct packed {
        logic               out_kind;
        logic [SESS_W-1:0]  meta_session;
        logic [LEN_W-1:0]   meta_length;
        logic [DATA_W-1:0]  out_data;
        logic [KEEP_W-1:0]  out_keep;
        logic [DEST_W-1:0]  out_dest;
        logic               out_last;
    } t_out_item;

endpackage

@@ src/tcp_tx_segmenter.sv @@
// Top level: TCP transmit segmenter with input and result registers around the core.
//
// The block takes one transaction per cycle on the input channel while the
// result side does not stall, and gives at most one result per input: a
// command opens a transfer and asks for the first packet of
// min(limit*WORD_BYTES, total) bytes, an accepted transmit status books its
// length and asks for the next packet (full or the remainder, none after the
// last), a retry status asks again for the same length, and payload words are
// forwarded with the last word of each packet marked. Items whose kind does not
// suit the current phase are dropped without a result. Each transaction passes
// through the input register and then the result register, and the state
// update in the core keeps up with that rate. Back-pressure on the result side
// stalls both registers.
module tcp_tx_segmenter
    import tcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [SESS_W-1:0]  i_session_id,
    input  logic [BYTES_W-1:0] i_total_bytes,
    input  logic [BYTES_W-1:0] i_max_words,
    input  logic [LEN_W-1:0]   i_status_length,
    input  logic [1:0]         i_status_error,
    input  logic [DATA_W-1:0]  i_in_data,
    input  logic [KEEP_W-1:0]  i_in_keep,
    input  logic [DEST_W-1:0]  i_in_dest,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_out_kind,
    output logic [SESS_W-1:0]  o_meta_session,
    output logic [LEN_W-1:0]   o_meta_length,
    output logic [DATA_W-1:0]  o_out_data,
    output logic [KEEP_W-1:0]  o_out_keep,
    output logic [DEST_W-1:0]  o_out_dest,
    output logic               o_out_last
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_adv;
    logic      w_fire;
    logic      w_res_valid;
    t_out_item w_res;

    // advance the pipeline whenever the result register is free or being drained
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    // register the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.kind          <= i_kind;
            r_in.session_id    <= i_session_id;
            r_in.total_bytes   <= i_total_bytes;
            r_in.max_words     <= i_max_words;
            r_in.status_length <= i_status_length;
            r_in.status_error  <= i_status_error;
            r_in.in_data       <= i_in_data;
            r_in.in_keep       <= i_in_keep;
            r_in.in_dest       <= i_in_dest;
        end
    end

    tcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // capture the result; a dropped item leaves the register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out.out_kind;
    assign o_meta_session = r_out.meta_session;
    assign o_meta_length  = r_out.meta_length;
    assign o_out_data     = r_out.out_data;
    assign o_out_keep     = r_out.out_keep;
    assign o_out_dest     = r_out.out_dest;
    assign o_out_last     = r_out.out_last;

endmodule

@@ src/tcs_core.sv @@
// Segmenter core: transfer state registers and the per-transaction decision logic.
module tcs_core
    import tcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_phase             r_phase, n_phase;
    logic [SESS_W-1:0]  r_session, n_session;
    logic [BYTES_W-1:0] r_total, n_total;
    logic [BYTES_W-1:0] r_full, n_full;
    logic [BYTES_W-1:0] r_sent, n_sent;
    logic [CNT_W-1:0]   r_pw, n_pw;
    logic [CNT_W-1:0]   r_wc, n_wc;

    logic [BYTES_W-1:0] w_cmd_full;
    logic [BYTES_W-1:0] w_sum;
    logic [BYTES_W-1:0] w_sum_full;
    logic [BYTES_W-1:0] w_rest;
    logic [QIN_W-1:0]   w_qin;
    logic [PROD_W-1:0]  w_prod;
    logic [CNT_W-1:0]   w_pkt_words;
    logic [CNT_W-1:0]   w_wc_inc;
    logic               w_last;

    assign w_cmd_full  = BYTES_W'(i_item.max_words * BYTES_W'(WORD_BYTES));
    assign w_sum       = r_sent + BYTES_W'(i_item.status_length);
    assign w_sum_full  = w_sum + r_full;
    assign w_rest      = r_total - w_sum;
    assign w_qin       = QIN_W'(i_item.status_length) + QIN_W'(WORD_BYTES - 1);
    assign w_prod      = PROD_W'(w_qin) * PROD_W'(RECIP);
    assign w_pkt_words = w_prod[RECIP_SH +: CNT_W];
    assign w_wc_inc    = r_wc + CNT_W'(1);
    assign w_last      = (w_wc_inc >= r_pw);

    always_comb begin
        n_phase     = r_phase;
        n_session   = r_session;
        n_total     = r_total;
        n_full      = r_full;
        n_sent      = r_sent;
        n_pw        = r_pw;
        n_wc        = r_wc;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.kind == KIND_CMD) begin
                    n_session          = i_item.session_id;
                    n_total            = i_item.total_bytes;
                    n_full             = w_cmd_full;
                    o_res_valid        = 1'b1;
                    o_res.out_kind     = OUT_META;
                    o_res.meta_session = i_item.session_id;
                    o_res.meta_length  = (w_cmd_full > i_item.total_bytes) ?
                                         i_item.total_bytes[LEN_W-1:0] :
                                         w_cmd_full[LEN_W-1:0];
                    n_phase            = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (i_item.kind == KIND_STATUS) begin
                    n_session = i_item.session_id;
                    n_pw      = w_pkt_words;
                    o_res.out_kind     = OUT_META;
                    o_res.meta_session = i_item.session_id;
                    if (i_item.status_error == ERR_OK) begin
                        n_sent  = w_sum;
                        n_phase = PH_WORDS;
                        if (w_sum < r_total) begin
                            o_res_valid       = 1'b1;
                            o_res.meta_length = (w_sum_full < r_total) ?
                                                r_full[LEN_W-1:0] :
                                                w_rest[LEN_W-1:0];
                        end
                    end else if (i_item.status_error != ERR_CLOSED) begin
                        // retry: ask again for the length that the status carries
                        o_res_valid       = 1'b1;
                        o_res.meta_length = i_item.status_length;
                    end
                end
            end
            PH_WORDS: begin
                if (i_item.kind == KIND_DATA) begin
                    o_res_valid    = 1'b1;
                    o_res.out_kind = OUT_WORD;
                    o_res.out_data = i_item.in_data;
                    o_res.out_keep = i_item.in_keep;
                    o_res.out_dest = i_item.in_dest;
                    o_res.out_last = w_last;
                    if (w_last) begin
                        n_wc = '0;
                        if (r_sent >= r_total) begin
                            n_sent  = '0;
                            n_pw    = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_STATUS;
                        end
                    end else begin
                        n_wc = w_wc_inc;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sent  <= '0;
            r_pw    <= '0;
            r_wc    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_sent  <= n_sent;
            r_pw    <= n_pw;
            r_wc    <= n_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_session <= n_session;
            r_total   <= n_total;
            r_full    <= n_full;
        end
    end

endmodule

@@ tb/tb_tcp_tx_segmenter.sv @@
// Testbench: self-checking random and directed test of the TCP transmit segmenter.
module tb_tcp_tx_segmenter
    import tcs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_RANDOM    = 660;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN       = 20;
    localparam int BIG_QUIET   = 300;

    // Segmenter predictor and store of awaited results. Each accepted input
    // transaction advances the predicted transfer state and queues the
    // result it causes; each accepted result is checked against the head.
    class seg_scoreboard;
        t_phase             phase;
        logic [SESS_W-1:0]  held_session;
        logic [BYTES_W-1:0] transfer_bytes;
        logic [BYTES_W-1:0] limit_words;
        logic [BYTES_W-1:0] sent_bytes;
        logic [CNT_W-1:0]   packet_words;
        logic [CNT_W-1:0]   word_count;
        logic [LEN_W-1:0]   last_req;
        t_out_item          awaited[$];
        int errors, n_transfers, n_meta, n_word, n_drop, n_retry, n_closed, n_checked;

        function new();
            phase          = PH_IDLE;
            held_session   = '0;
            transfer_bytes = '0;
            limit_words    = '0;
            sent_bytes     = '0;
            packet_words   = '0;
            word_count     = '0;
            last_req       = '0;
        endfunction

        function void push_meta(logic [SESS_W-1:0] sess, logic [BYTES_W-1:0] len);
            t_out_item r;
            r              = '0;
            r.out_kind     = OUT_META;
            r.meta_session = sess;
            r.meta_length  = len[LEN_W-1:0];
            last_req       = len[LEN_W-1:0];
            awaited.push_back(r);
            n_meta++;
        endfunction

        // Returns 1 when the item is taken, 0 when the block drops it.
        function bit note_input(t_in_item it);
            t_out_item          r;
            logic [BYTES_W-1:0] full;
            logic [BYTES_W-1:0] reach;
            logic [BYTES_W-1:0] words;
            logic [CNT_W-1:0]   next_count;
            case (phase)
                PH_IDLE: begin
                    if (it.kind != KIND_CMD) begin
                        n_drop++;
                        return 1'b0;
                    end
                    held_session   = it.session_id;
                    transfer_bytes = it.total_bytes;
                    limit_words    = it.max_words;
                    full           = limit_words * BYTES_W'(WORD_BYTES);
                    push_meta(held_session, (full > transfer_bytes) ? transfer_bytes : full);
                    phase = PH_STATUS;
                    n_transfers++;
                end
                PH_STATUS: begin
                    if (it.kind != KIND_STATUS) begin
                        n_drop++;
                        return 1'b0;
                    end
                    held_session = it.session_id;
                    words = (BYTES_W'(it.status_length) + BYTES_W'(WORD_BYTES) - 1)
                            / BYTES_W'(WORD_BYTES);
                    packet_words = words[CNT_W-1:0];
                    if (it.status_error == ERR_OK) begin
                        sent_bytes = sent_bytes + BYTES_W'(it.status_length);
                        if (sent_bytes < transfer_bytes) begin
                            full  = limit_words * BYTES_W'(WORD_BYTES);
                            reach = sent_bytes + full;
                            push_meta(held_session, (reach < transfer_bytes) ? full
                                                    : transfer_bytes - sent_bytes);
                        end
                        phase = PH_WORDS;
                    end else if (it.status_error == ERR_CLOSED) begin
                        n_closed++;
                    end else begin
                        push_meta(held_session, BYTES_W'(it.status_length));
                        n_retry++;
                    end
                end
                default: begin
                    if (it.kind != KIND_DATA) begin
                        n_drop++;
                        return 1'b0;
                    end
                    next_count = word_count + 1'b1;
                    r          = '0;
                    r.out_kind = OUT_WORD;
                    r.out_data = it.in_data;
                    r.out_keep = it.in_keep;
                    r.out_dest = it.in_dest;
                    r.out_last = (next_count >= packet_words);
                    awaited.push_back(r);
                    n_word++;
                    if (r.out_last) begin
                        word_count = '0;
                        if (sent_bytes >= transfer_bytes) begin
                            sent_bytes   = '0;
                            packet_words = '0;
                            phase        = PH_IDLE;
                        end else begin
                            phase = PH_STATUS;
                        end
                    end else begin
                        word_count = next_count;
                    end
                end
            endcase
            return 1'b1;
        endfunction

        function void cmp(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, seen);
            end
        endfunction

        function void check_result(t_out_item seen);
            t_out_item want;
            n_checked++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with nothing awaited, expected none, got kind %0d",
                         $time, seen.out_kind);
                return;
            end
            want = awaited.pop_front();
            cmp("out_kind",     want.out_kind,     seen.out_kind);
            cmp("meta_session", want.meta_session, seen.meta_session);
            cmp("meta_length",  want.meta_length,  seen.meta_length);
            cmp("out_data",     want.out_data,     seen.out_data);
            cmp("out_keep",     want.out_keep,     seen.out_keep);
            cmp("out_dest",     want.out_dest,     seen.out_dest);
            cmp("out_last",     want.out_last,     seen.out_last);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic [SESS_W-1:0]  i_session_id;
    logic [BYTES_W-1:0] i_total_bytes;
    logic [BYTES_W-1:0] i_max_words;
    logic [LEN_W-1:0]   i_status_length;
    logic [1:0]         i_status_error;
    logic [DATA_W-1:0]  i_in_data;
    logic [KEEP_W-1:0]  i_in_keep;
    logic [DEST_W-1:0]  i_in_dest;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_out_kind;
    logic [SESS_W-1:0]  o_meta_session;
    logic [LEN_W-1:0]   o_meta_length;
    logic [DATA_W-1:0]  o_out_data;
    logic [KEEP_W-1:0]  o_out_keep;
    logic [DEST_W-1:0]  o_out_dest;
    logic               o_out_last;

    seg_scoreboard sb = new();

    int  n_cycles  = 0;
    int  n_taken   = 0;
    int  in_quiet  = 0;
    int  out_quiet = 0;
    bit  hold_long = 1'b0;

    tcp_tx_segmenter dut (.*);

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     n_cycles, sb.awaited.size());
            $display("FAIL tcp_tx_segmenter");
            $finish;
        end
    end

    // Draw a random idle gap; now and then open a quiet stretch
    // with no idling at all, so that back-to-back transactions occur too.
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Fill every field at random; the fields a kind does not use must be ignored.
    function automatic t_in_item make_item(logic [1:0] kind);
        t_in_item it;
        it.kind          = kind;
        it.session_id    = SESS_W'($urandom);
        it.total_bytes   = $urandom;
        it.max_words     = $urandom;
        it.status_length = LEN_W'($urandom);
        it.status_error  = 2'($urandom);
        it.in_data       = {$urandom, $urandom};
        it.in_keep       = KEEP_W'($urandom);
        it.in_dest       = DEST_W'($urandom);
        return it;
    endfunction

    // Offer one transaction and hold it until accepted. Entered and left
    // just after a falling edge; valid stays high across back-to-back items.
    task automatic send_item(t_in_item it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : draw_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind          <= it.kind;
        i_session_id    <= it.session_id;
        i_total_bytes   <= it.total_bytes;
        i_max_words     <= it.max_words;
        i_status_length <= it.status_length;
        i_status_error  <= it.status_error;
        i_in_data       <= it.in_data;
        i_in_keep       <= it.in_keep;
        i_in_dest       <= it.in_dest;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.note_input(it))
            n_taken++;
        @(negedge i_clk);
    endtask

    task automatic send_cmd(logic [SESS_W-1:0] sess, logic [BYTES_W-1:0] total,
                            logic [BYTES_W-1:0] maxw);
        t_in_item it;
        it             = make_item(KIND_CMD);
        it.session_id  = sess;
        it.total_bytes = total;
        it.max_words   = maxw;
        send_item(it, 1'b0);
    endtask

    task automatic send_status(logic [SESS_W-1:0] sess, logic [LEN_W-1:0] len,
                               logic [1:0] err);
        t_in_item it;
        it               = make_item(KIND_STATUS);
        it.session_id    = sess;
        it.status_length = len;
        it.status_error  = err;
        send_item(it, 1'b0);
    endtask

    task automatic send_word(logic [DATA_W-1:0] data, logic [KEEP_W-1:0] keep,
                             logic [DEST_W-1:0] dest);
        t_in_item it;
        it         = make_item(KIND_DATA);
        it.in_data = data;
        it.in_keep = keep;
        it.in_dest = dest;
        send_item(it, 1'b0);
    endtask

    // One random transaction, shaped by the predicted phase: mostly the kind
    // the block is waiting for, with plausible lengths, and some stray kinds.
    task automatic random_step();
        t_in_item   it;
        logic [1:0] want;
        logic [1:0] stray;
        int         r;
        want = (sb.phase == PH_IDLE)   ? KIND_CMD :
               (sb.phase == PH_STATUS) ? KIND_STATUS : KIND_DATA;
        if ($urandom_range(0, 99) < 8) begin
            do stray = 2'($urandom_range(0, 3)); while (stray == want);
            it = make_item(stray);
        end else begin
            it = make_item(want);
            case (want)
                KIND_CMD: begin
                    r = $urandom_range(0, 99);
                    it.total_bytes = (r < 10) ? 0 :
                                     (r < 65) ? $urandom_range(1, 300)
                                              : $urandom_range(301, 2000);
                    r = $urandom_range(0, 99);
                    it.max_words = (r < 60) ? $urandom_range(0, 16) :
                                   (r < 85) ? $urandom_range(17, 200) : $urandom;
                end
                KIND_STATUS: begin
                    r = $urandom_range(0, 99);
                    it.status_error = (r < 78) ? ERR_OK :
                                      (r < 88) ? ERR_CLOSED : 2'($urandom_range(2, 3));
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        it.status_length = (sb.last_req <= 400) ? sb.last_req
                                           : LEN_W'($urandom_range(0, 400));
                    else if (r < 90)
                        it.status_length = LEN_W'($urandom_range(0, 64));
                    else if (it.status_error != ERR_OK)
                        it.status_length = LEN_W'($urandom_range(0, 65535));
                    else
                        it.status_length = LEN_W'($urandom_range(0, 400));
                end
                default: ;
            endcase
        end
        send_item(it, 1'b0);
    endtask

    // Result sink: stall at random, once for a long stretch on request,
    // and check every accepted result against the predictor.
    initial begin
        t_out_item seen;
        int        stall;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                stall     = LONG_HOLD;
            end else begin
                stall = draw_gap(out_quiet);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            seen.out_kind     = o_out_kind;
            seen.meta_session = o_meta_session;
            seen.meta_length  = o_meta_length;
            seen.out_data     = o_out_data;
            seen.out_keep     = o_out_keep;
            seen.out_dest     = o_out_dest;
            seen.out_last     = o_out_last;
            sb.check_result(seen);
            @(negedge i_clk);
        end
    end

    // Stimulus and end of run
    initial begin
        int start;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_kind          = KIND_CMD;
        i_session_id    = '0;
        i_total_bytes   = '0;
        i_max_words     = '0;
        i_status_length = '0;
        i_status_error  = ERR_OK;
        i_in_data       = '0;
        i_in_keep       = '0;
        i_in_dest       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stray kinds while idle, an unused kind among them: drop both
        send_item(make_item(KIND_DATA), 1'b0);
        send_item(make_item(2'd3), 1'b0);
        // Open a 20-byte transfer with one-word packets
        send_cmd(16'hFFFF, 32'd20, 32'd1);
        send_item(make_item(KIND_DATA), 1'b0);
        send_item(make_item(KIND_CMD), 1'b0);
        // Closed connection books nothing; retries ask again for their own length
        send_status(16'h0000, 16'hFFFF, ERR_CLOSED);
        send_status(16'h1234, 16'hFFFF, 2'd2);
        send_status(16'hABCD, 16'h0000, 2'd3);
        // Full packet, then the remainder
        send_status(16'hFFFF, 16'd8, ERR_OK);
        send_word('1, '1, '1);
        send_status(16'hFFFF, 16'd8, ERR_OK);
        send_word('0, '0, '0);
        // Zero-length packet: the first word is the last
        send_status(16'hABCD, 16'd0, ERR_OK);
        send_word({$urandom, $urandom}, KEEP_W'($urandom), DEST_W'($urandom));
        // Overshoot the total: last packet, no further request
        send_status(16'hABCD, 16'd12, ERR_OK);
        send_item(make_item(KIND_STATUS), 1'b0);
        send_word({$urandom, $urandom}, KEEP_W'($urandom), DEST_W'($urandom));
        send_word({$urandom, $urandom}, KEEP_W'($urandom), DEST_W'($urandom));
        // Empty transfer with the largest limit; the limit product wraps
        send_cmd(16'h0000, 32'd0, 32'hFFFF_FFFF);
        send_status(16'h0000, 16'd0, ERR_OK);
        send_word({$urandom, $urandom}, KEEP_W'($urandom), DEST_W'($urandom));
        // Limit whose byte product wraps to one word
        send_cmd(16'h5A5A, 32'd16, 32'h2000_0001);
        send_status(16'h5A5A, 16'd16, ERR_OK);
        while (sb.phase == PH_WORDS)
            send_item(make_item(KIND_DATA), 1'b0);

        // Back-pressure: hold the sink off while a 40-word packet streams in
        hold_long = 1'b1;
        send_cmd(16'($urandom), 32'd320, 32'd40);
        send_status(sb.held_session, 16'd320, ERR_OK);
        while (sb.phase == PH_WORDS)
            send_item(make_item(KIND_DATA), 1'b0);

        // Long packet of 250 words, run back to back on both sides
        in_quiet  = BIG_QUIET;
        out_quiet = BIG_QUIET;
        send_cmd(16'($urandom), 32'd2000, 32'd8192);
        send_status(sb.held_session, 16'd2000, ERR_OK);
        while (sb.phase == PH_WORDS)
            send_item(make_item(KIND_DATA), 1'b0);

        // Random transfers; finish the one in flight before leaving
        start = n_taken;
        while ((n_taken - start) < N_RANDOM || sb.phase != PH_IDLE)
            random_step();

        // Leave a huge transfer open: the next-request sum wraps past zero
        send_cmd(16'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_status(sb.held_session, 16'd100, ERR_OK);
        while (sb.phase == PH_WORDS)
            send_item(make_item(KIND_DATA), 1'b0);
        send_status(16'($urandom), 16'hFFFF, ERR_CLOSED);
        send_status(16'($urandom), 16'hFFFF, 2'd3);
        i_in_valid <= 1'b0;

        // Drain, then allow for anything the block should not have produced
        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Ran %0d transfers: %0d packet requests and %0d payload words, %0d checked",
                 sb.n_transfers, sb.n_meta, sb.n_word, sb.n_checked);
        $display("Also %0d strays dropped, %0d retries, %0d closed, %0d-cycle sink hold",
                 sb.n_drop, sb.n_retry, sb.n_closed, LONG_HOLD);
        if (sb.errors == 0) begin
            $display("PASS tcp_tx_segmenter");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL tcp_tx_segmenter");
        end
        $finish;
    end

endmodule

@@ tcp_tx_segmenter.f @@
src/tcs_pkg.sv
src/tcs_core.sv
src/tcp_tx_segmenter.sv
tb/tb_tcp_tx_segmenter.sv
